### rtl/drnm_pkg.sv
package drnm_pkg;

  localparam int EtaW  = 14;
  localparam int PhiW  = 13;
  localparam int PtW   = 16;
  localparam int DrW   = 13;
  localparam int DistW = 34;
  localparam int PosW  = 6;
  localparam int SqW   = 29;
  localparam int LimW  = 26;
  localparam int CfgAW = 3;
  localparam int CfgDW = 16;

  localparam logic signed [PhiW:0] PHI_PI     = 14'sd3217;
  localparam logic signed [PhiW:0] PHI_TWO_PI = 14'sd6434;
  localparam logic [DrW:0]         DR_ONE     = 14'd1024;
  localparam logic [PtW:0]         PT_ONE     = 17'd16;
  localparam logic [DistW-1:0]     DR_START_SQ = 34'd10485760000;

  localparam logic [CfgAW-1:0] REG_REF_ETA   = 3'd0;
  localparam logic [CfgAW-1:0] REG_REF_PHI   = 3'd1;
  localparam logic [CfgAW-1:0] REG_REF_PT    = 3'd2;
  localparam logic [CfgAW-1:0] REG_DR_LIMIT  = 3'd3;
  localparam logic [CfgAW-1:0] REG_DPT_LIMIT = 3'd4;
  localparam logic [CfgAW-1:0] REG_PT_MODE   = 3'd5;

  localparam logic [DrW-1:0] DR_LIMIT_RST  = 13'd410;
  localparam logic [PtW-1:0] DPT_LIMIT_RST = 16'd65535;

endpackage

### rtl/delta_r_nearest_match.sv
// A final or absent request yields its result in out_tdata after passing through the input
// register, squares register and result register.
// Throughput: one candidate per cycle unless a final or absent request is held; the running-minimum
// compare is combinational. Non-final candidates keep flowing while a result waits on out_tready.
// Reset: rst_n is synchronous, active low; it clears the list state and loads register defaults.
module delta_r_nearest_match #(
  parameter int MAX_CANDS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,   // cand_eta[13:0], cand_phi[26:14], cand_pt[42:27]
  input  logic                           in_tlast,
  input  logic                           in_tuser,   // absent
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // match_index[5:0], best_dr_sq[39:6]
  output logic                           out_tuser,  // matched
  input  logic                           cfg_we,
  input  logic [drnm_pkg::CfgAW-1:0]     cfg_addr,
  input  logic [drnm_pkg::CfgDW-1:0]     cfg_wdata
);
  import drnm_pkg::*;

  localparam int CntW = $clog2(MAX_CANDS + 1);

  // configuration
  logic signed [EtaW-1:0] ref_eta_r;
  logic signed [PhiW-1:0] ref_phi_r;
  logic [PtW-1:0]         ref_pt_r;
  logic [DrW-1:0]         dr_limit_r;
  logic [PtW-1:0]         dpt_limit_r;
  logic                   pt_mode_r;
  logic [DistW-1:0]       start_dist_r;
  logic [PtW:0]           start_pt_r;
  logic [LimW-1:0]        lim_sq_r;
  logic [DrW:0]           dr_start;

  // pipeline
  logic                   s1_v_r, s1_last_r, s1_absent_r;
  logic signed [EtaW-1:0] s1_eta_r;
  logic signed [PhiW-1:0] s1_phi_r;
  logic [PtW-1:0]         s1_pt_r;
  logic                   s2_v_r, s2_last_r, s2_absent_r;
  logic [SqW-1:0]         s2_d2_r;
  logic [PtW-1:0]         s2_dpt_r;

  // list state
  logic [DistW-1:0]       best_dist_r, best_dist_nxt;
  logic [PtW:0]           best_pt_r, best_pt_nxt;
  logic [PosW-1:0]        best_pos_r, best_pos_nxt;
  logic                   found_r, found_nxt;
  logic [CntW-1:0]        item_cnt_r;

  logic                   out_valid_r, out_matched_r;
  logic [PosW-1:0]        out_index_r;
  logic [DistW-1:0]       out_dr_r;

  logic                   in_fire, ready2, fire2, s2_res, out_free;
  logic signed [EtaW:0]   deta;
  logic signed [PhiW:0]   dphi_raw, dphi;
  logic [EtaW-1:0]        ae;
  logic [11:0]            ap;
  logic [2*EtaW-1:0]      sq_e;
  logic [23:0]            sq_p;
  logic [SqW-1:0]         d2;
  logic [PtW-1:0]         dpt;
  logic                   cnt_zero, in_range, better, ok;
  logic [DistW-1:0]       cur_best;
  logic [PtW:0]           cur_pt;
  logic [PosW-1:0]        cur_pos;
  logic                   cur_found;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s2_res    = s2_last_r || s2_absent_r;
  assign fire2     = s2_v_r && (!s2_res || out_free);
  assign ready2    = !s2_v_r || fire2;
  assign in_tready = !s1_v_r || ready2;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_eta_r   <= '0;
      ref_phi_r   <= '0;
      ref_pt_r    <= '0;
      dr_limit_r  <= DR_LIMIT_RST;
      dpt_limit_r <= DPT_LIMIT_RST;
      pt_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_REF_ETA:   ref_eta_r   <= cfg_wdata[EtaW-1:0];
        REG_REF_PHI:   ref_phi_r   <= cfg_wdata[PhiW-1:0];
        REG_REF_PT:    ref_pt_r    <= cfg_wdata[PtW-1:0];
        REG_DR_LIMIT:  dr_limit_r  <= cfg_wdata[DrW-1:0];
        REG_DPT_LIMIT: dpt_limit_r <= cfg_wdata[PtW-1:0];
        REG_PT_MODE:   pt_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // derived limits, refreshed every cycle from the registers
  assign dr_start = {1'b0, dr_limit_r} + DR_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_dist_r <= DR_START_SQ;
      start_pt_r   <= {1'b0, DPT_LIMIT_RST} + PT_ONE;
      lim_sq_r     <= LimW'({13'd0, DR_LIMIT_RST} * {13'd0, DR_LIMIT_RST});
    end else begin
      start_dist_r <= pt_mode_r ? DistW'({14'd0, dr_start} * {14'd0, dr_start}) : DR_START_SQ;
      start_pt_r   <= {1'b0, dpt_limit_r} + PT_ONE;
      lim_sq_r     <= LimW'({13'd0, dr_limit_r} * {13'd0, dr_limit_r});
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_eta_r    <= in_tdata[13:0];
      s1_phi_r    <= in_tdata[26:14];
      s1_pt_r     <= in_tdata[42:27];
      s1_last_r   <= in_tlast;
      s1_absent_r <= in_tuser;
    end
  end

  // distance terms
  always_comb begin
    deta     = (EtaW+1)'(s1_eta_r) - (EtaW+1)'(ref_eta_r);
    dphi_raw = (PhiW+1)'(s1_phi_r) - (PhiW+1)'(ref_phi_r);
    if (dphi_raw > PHI_PI) begin
      dphi = dphi_raw - PHI_TWO_PI;
    end else if (dphi_raw < -PHI_PI) begin
      dphi = dphi_raw + PHI_TWO_PI;
    end else begin
      dphi = dphi_raw;
    end
    ae   = deta[EtaW] ? EtaW'(-deta) : EtaW'(deta);
    ap   = dphi[PhiW] ? 12'(-dphi) : 12'(dphi);
    sq_e = ae * ae;
    sq_p = ap * ap;
    d2   = SqW'(sq_e) + SqW'(sq_p);
    dpt  = (s1_pt_r > ref_pt_r) ? (s1_pt_r - ref_pt_r) : (ref_pt_r - s1_pt_r);
  end

  // stage 2: squares register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ready2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_v_r) begin
      s2_d2_r     <= d2;
      s2_dpt_r    <= dpt;
      s2_last_r   <= s1_last_r;
      s2_absent_r <= s1_absent_r;
    end
  end

  // running minimum; a list starts from the limits in force at its first candidate
  always_comb begin
    cnt_zero  = (item_cnt_r == '0);
    in_range  = (item_cnt_r < CntW'(MAX_CANDS));
    cur_best  = cnt_zero ? start_dist_r : best_dist_r;
    cur_pt    = cnt_zero ? start_pt_r : best_pt_r;
    cur_pos   = cnt_zero ? '0 : best_pos_r;
    cur_found = cnt_zero ? 1'b0 : found_r;
    better    = in_range && (DistW'(s2_d2_r) < cur_best) &&
                (!pt_mode_r || ({1'b0, s2_dpt_r} < cur_pt));
    best_dist_nxt = better ? DistW'(s2_d2_r) : cur_best;
    best_pt_nxt   = (better && pt_mode_r) ? {1'b0, s2_dpt_r} : cur_pt;
    best_pos_nxt  = better ? PosW'(item_cnt_r) : cur_pos;
    found_nxt     = cur_found || better;
    ok = found_nxt && (best_dist_nxt < DistW'(lim_sq_r)) &&
         (!pt_mode_r || (best_pt_nxt < {1'b0, dpt_limit_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
      found_r    <= 1'b0;
    end else if (fire2) begin
      if (s2_res) begin
        item_cnt_r <= '0;
        found_r    <= 1'b0;
      end else begin
        item_cnt_r <= in_range ? item_cnt_r + 1'b1 : item_cnt_r;
        found_r    <= found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      best_dist_r <= best_dist_nxt;
      best_pt_r   <= best_pt_nxt;
      best_pos_r  <= best_pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire2 && s2_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && s2_res) begin
      out_matched_r <= !s2_absent_r && ok;
      out_index_r   <= (!s2_absent_r && ok) ? best_pos_nxt : '0;
      out_dr_r      <= (!s2_absent_r && ok) ? best_dist_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_matched_r;
  assign out_tdata  = {out_dr_r, out_index_r};

`ifndef SYNTHESIS
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_matched_r |-> (out_index_r == '0) && (out_dr_r == '0))
    else $error("unmatched result carries nonzero payload");

  a_match_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_matched_r |-> out_dr_r < DistW'(lim_sq_r))
    else $error("matched result exceeds delta R limit");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_cnt_r <= CntW'(MAX_CANDS))
    else $error("candidate counter past saturation");

  a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fire2 && s2_res |=> (item_cnt_r == '0) && !found_r)
    else $error("list state not cleared after final or absent request");
`endif

endmodule

### tb/tb_delta_r_nearest_match.sv
`timescale 1ns / 1ps

module tb_delta_r_nearest_match;

  localparam int MaxCands    = 64;
  localparam int PhiHalfTurn = 3217;
  localparam int PhiFullTurn = 6434;
  localparam int DrUnit      = 1024;
  localparam int PtUnit      = 16;
  localparam longint unsigned FarDistSq = 64'd10485760000;
  localparam int QuietLimit  = 4000;
  localparam int SettleCycles = 6;

  typedef struct {
    logic signed [13:0] eta;
    logic signed [12:0] phi;
    logic [15:0]        pt;
    logic               last;
    logic               absent;
  } cand_req_t;

  typedef struct {
    logic        matched;
    logic [5:0]  index;
    logic [33:0] dr_sq;
  } match_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;   // cand_eta[13:0], cand_phi[26:14], cand_pt[42:27]
  logic in_tlast = 1'b0;
  logic in_tuser = 1'b0;        // absent
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;       // match_index[5:0], best_dr_sq[39:6]
  logic out_tuser;              // matched
  logic cfg_we = 1'b0;
  logic [drnm_pkg::CfgAW-1:0] cfg_addr = '0;
  logic [drnm_pkg::CfgDW-1:0] cfg_wdata = '0;

  delta_r_nearest_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // matcher settings as last written
  logic signed [13:0] set_eta = '0;
  logic signed [12:0] set_phi = '0;
  logic [15:0]        set_pt = '0;
  logic [12:0]        set_dr_cut = drnm_pkg::DR_LIMIT_RST;
  logic [15:0]        set_dpt_cut = drnm_pkg::DPT_LIMIT_RST;
  logic               set_pt_mode = 1'b0;

  // running state of the open candidate list
  logic [33:0] near_dist_sq = '0;
  logic [16:0] near_dpt = '0;
  logic [5:0]  near_pos = '0;
  logic        near_found = 1'b0;
  int          list_pos = 0;

  cand_req_t  pending_cands[$];
  match_res_t awaited_matches[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_kick = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  cand_req_t  drive_req;
  cand_req_t  seen_req;
  match_res_t seen_res;
  match_res_t want_res;

  function automatic void close_list();
    near_dist_sq = '0;
    near_dpt = '0;
    near_pos = '0;
    near_found = 1'b0;
    list_pos = 0;
  endfunction

  function automatic bit match_outcome(input cand_req_t c, output match_res_t r);
    int deta, dphi, ae, ap, dpt, start;
    longint unsigned d2, cut_sq;
    bit better, ok;
    r.matched = 1'b0;
    r.index = '0;
    r.dr_sq = '0;
    if (c.absent) begin
      close_list();
      return 1'b1;
    end
    if (list_pos == 0) begin
      if (set_pt_mode) begin
        start = int'(set_dr_cut) + DrUnit;
        near_dist_sq = 34'(longint'(start) * longint'(start));
      end else begin
        near_dist_sq = 34'(FarDistSq);
      end
      near_dpt = 17'(int'(set_dpt_cut) + PtUnit);
    end
    if (list_pos < MaxCands) begin
      deta = int'(c.eta) - int'(set_eta);
      dphi = int'(c.phi) - int'(set_phi);
      if (dphi > PhiHalfTurn) begin
        dphi = dphi - PhiFullTurn;
      end else if (dphi < -PhiHalfTurn) begin
        dphi = dphi + PhiFullTurn;
      end
      ae = (deta < 0) ? -deta : deta;
      ap = (dphi < 0) ? -dphi : dphi;
      d2 = longint'(ae) * longint'(ae) + longint'(ap) * longint'(ap);
      dpt = (int'(c.pt) > int'(set_pt)) ? int'(c.pt) - int'(set_pt)
                                        : int'(set_pt) - int'(c.pt);
      better = d2 < near_dist_sq;
      if (set_pt_mode) begin
        better = better && (dpt < near_dpt);
      end
      if (better) begin
        near_dist_sq = d2[33:0];
        if (set_pt_mode) begin
          near_dpt = 17'(dpt);
        end
        near_pos = 6'(list_pos);
        near_found = 1'b1;
      end
      list_pos++;
    end
    if (!c.last) begin
      return 1'b0;
    end
    cut_sq = longint'(set_dr_cut) * longint'(set_dr_cut);
    ok = near_found && (near_dist_sq < cut_sq);
    if (set_pt_mode) begin
      ok = ok && (near_dpt < set_dpt_cut);
    end
    if (ok) begin
      r.matched = 1'b1;
      r.index = near_pos;
      r.dr_sq = near_dist_sq;
    end
    close_list();
    return 1'b1;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_cands.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {5'b0, drive_req.pt, drive_req.phi, drive_req.eta};
        in_tlast <= drive_req.last;
        in_tuser <= drive_req.absent;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen_req.eta = in_tdata[13:0];
      seen_req.phi = in_tdata[26:14];
      seen_req.pt = in_tdata[42:27];
      seen_req.last = in_tlast;
      seen_req.absent = in_tuser;
      if (match_outcome(seen_req, seen_res)) begin
        awaited_matches = {awaited_matches, seen_res};
      end
    end
  end

  // result sink with random and long stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_kick) begin
      stall_left <= 400;
      stall_seen <= stall_kick;
    end
    out_tready <= (stall_left == 0) && (stall_seen == stall_kick) &&
                  ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_matches.size() == 0) begin
        $error("unexpected result: matched %0b match_index %0d best_dr_sq %0d",
               out_tuser, out_tdata[5:0], out_tdata[39:6]);
        mismatch_count++;
      end else begin
        want_res = awaited_matches.pop_front();
        if (out_tuser !== want_res.matched) begin
          $error("matched: expected %0b, got %0b", want_res.matched, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[5:0] !== want_res.index) begin
          $error("match_index: expected %0d, got %0d", want_res.index, out_tdata[5:0]);
          mismatch_count++;
        end
        if (out_tdata[39:6] !== want_res.dr_sq) begin
          $error("best_dr_sq: expected %0d, got %0d", want_res.dr_sq, out_tdata[39:6]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_cand(input int eta, input int phi, input int pt,
                           input logic last, input logic absent);
    cand_req_t c;
    c.eta = eta[13:0];
    c.phi = phi[12:0];
    c.pt = pt[15:0];
    c.last = last;
    c.absent = absent;
    pending_cands = {pending_cands, c};
  endtask

  function automatic int pick_eta();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return int'(set_eta) + int'($urandom_range(1200)) - 600;
    end else if (r < 90) begin
      return int'($urandom_range(10240)) - 5120;
    end
    return int'($urandom_range(16383));
  endfunction

  function automatic int pick_phi();
    int r, v;
    r = $urandom_range(99);
    if (r < 60) begin
      v = int'(set_phi) + int'($urandom_range(1200)) - 600;
      if (v > PhiHalfTurn) begin
        v = v - PhiFullTurn;
      end else if (v < -PhiHalfTurn) begin
        v = v + PhiFullTurn;
      end
      return v;
    end else if (r < 90) begin
      return int'($urandom_range(6434)) - PhiHalfTurn;
    end
    return int'($urandom_range(8191));
  endfunction

  function automatic int pick_pt();
    int r, v;
    r = $urandom_range(99);
    if (r < 60) begin
      v = int'(set_pt) + int'($urandom_range(600)) - 300;
    end else if (r < 80) begin
      v = int'(set_pt) + int'($urandom_range(40)) - 20;
    end else begin
      v = int'($urandom_range(65535));
    end
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return v;
  endfunction

  task automatic push_sequence(inout int count);
    int kind, len, i;
    kind = $urandom_range(99);
    if (kind < 70) begin
      len = ($urandom_range(49) == 0) ? $urandom_range(70, 64) : $urandom_range(8, 1);
      for (i = 0; i < len; i++) begin
        push_cand(pick_eta(), pick_phi(), pick_pt(), i == len - 1, 1'b0);
      end
    end else if (kind < 80) begin
      len = 1;
      push_cand($urandom_range(16383), $urandom_range(8191), $urandom_range(65535),
                1'($urandom_range(1)), 1'b1);
    end else if (kind < 90) begin
      len = $urandom_range(5, 1);
      for (i = 0; i < len; i++) begin
        push_cand(pick_eta(), pick_phi(), pick_pt(), 1'b0, 1'b0);
      end
      push_cand(pick_eta(), pick_phi(), pick_pt(), 1'($urandom_range(1)), 1'b1);
      len++;
    end else begin
      len = $urandom_range(4, 1);
      for (i = 0; i < len; i++) begin
        push_cand($urandom_range(16383), $urandom_range(8191), $urandom_range(65535),
                  i == len - 1, 1'b0);
      end
    end
    count += len;
  endtask

  task automatic write_reg(input logic [drnm_pkg::CfgAW-1:0] addr, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val[15:0];
    case (addr)
      drnm_pkg::REG_REF_ETA:   set_eta = val[13:0];
      drnm_pkg::REG_REF_PHI:   set_phi = val[12:0];
      drnm_pkg::REG_REF_PT:    set_pt = val[15:0];
      drnm_pkg::REG_DR_LIMIT:  set_dr_cut = val[12:0];
      drnm_pkg::REG_DPT_LIMIT: set_dpt_cut = val[15:0];
      drnm_pkg::REG_PT_MODE:   set_pt_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int eta, input int phi, input int pt,
                              input int dr_cut, input int dpt_cut, input int mode);
    write_reg(drnm_pkg::REG_REF_ETA, eta & 'h3FFF);
    write_reg(drnm_pkg::REG_REF_PHI, phi & 'h1FFF);
    write_reg(drnm_pkg::REG_REF_PT, pt & 'hFFFF);
    write_reg(drnm_pkg::REG_DR_LIMIT, dr_cut & 'h1FFF);
    write_reg(drnm_pkg::REG_DPT_LIMIT, dpt_cut & 'hFFFF);
    write_reg(drnm_pkg::REG_PT_MODE, mode & 1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cands.size() != 0 || in_tvalid || awaited_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    int phase, items, i;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings
    send_idle_pct = 25;
    recv_idle_pct = 46;
    push_cand(0, 0, 0, 1'b0, 1'b1);
    push_cand(8191, -1, 65535, 1'b1, 1'b1);
    push_cand(0, 0, 0, 1'b1, 1'b0);
    push_cand(100, 0, 5, 1'b0, 1'b0);
    push_cand(0, 100, 7, 1'b0, 1'b0);        // tie, first one stays
    push_cand(-8192, 4095, 65535, 1'b1, 1'b0);
    push_cand(5120, 3217, 0, 1'b0, 1'b0);
    push_cand(-5120, -3217, 0, 1'b1, 1'b0);
    push_cand(10, 10, 0, 1'b0, 1'b0);
    push_cand(0, 0, 0, 1'b0, 1'b1);          // absent drops the open list
    push_cand(409, 0, 0, 1'b1, 1'b0);
    push_cand(410, 0, 0, 1'b1, 1'b0);        // exactly on the cut
    wait_idle();

    // directed, pt mode and phi wrap
    load_setting(-5120, 3000, 1000, 8191, 50, 1);
    push_cand(-5120, -3000, 1049, 1'b1, 1'b0);
    push_cand(-5120, 3000, 1050, 1'b0, 1'b0);
    push_cand(-5120, 3000, 1000, 1'b1, 1'b0); // same distance, so the earlier dpt equal to the cut stays best
    push_cand(-5100, 3000, 1010, 1'b0, 1'b0);
    push_cand(-5120, 3000, 1040, 1'b1, 1'b0); // closer but worse pt
    wait_idle();

    for (phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 25;
        recv_idle_pct = 46;
      end else if (phase < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: load_setting(-5120, -3217, 0, 0, 65535, 1);
        1: load_setting(5120, 3217, 65535, 8191, 0, 0);
        2: load_setting(0, 0, 32768, 8191, 65535, 1);
        default: begin
          load_setting(($urandom_range(3) == 0) ? int'($urandom_range(16383))
                                                : int'($urandom_range(10240)) - 5120,
                       ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                                : int'($urandom_range(6434)) - 3217,
                       $urandom_range(65535),
                       ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(1000),
                       ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(400),
                       $urandom_range(1));
        end
      endcase
      items = 0;
      if (phase == 3) begin
        for (i = 0; i < 70; i++) begin
          push_cand(pick_eta(), pick_phi(), pick_pt(), i == 69, 1'b0);
        end
        items = 70;
      end
      while (items < 90) begin
        push_sequence(items);
      end
      if (phase == 2 || phase == 10) begin
        stall_kick = stall_kick + 1;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && awaited_matches.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
